>>> rtl/bsdm_pkg.sv
// Package with the shared constants, codes and request and response types of the stack.
`default_nettype none
package bsdm_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DEPTH_W  = 7;

    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_TOP     = 3'd2,
        REQ_POP_TOP = 3'd3,
        REQ_CLEAR   = 3'd4,
        REQ_DELETE  = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DEL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    // The depth field is the fill count masked or zero-extended to the field width.
    function automatic logic [DEPTH_W-1:0] to_depth(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+DEPTH_W-1:0] wide;
        begin
            wide = {{DEPTH_W{1'b0}}, cnt};
            return wide[DEPTH_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/bounded_stack_with_delete_matching_core.sv
// Bounded LIFO stack with a delete-matching request, built around one entry memory.
// A request passes an execute state; top and pop-and-return on a non-empty stack then
// read the top entry, delete matching walks the stored entries, and each ends in a done
// state that loads the result. One request at a time; the next is taken the cycle after
// the result is loaded. The delete walk reads one entry per cycle through the one read port.
// Reset clears the fill count and the handshake state; memory contents are left as they are.
`default_nettype none
module bounded_stack_with_delete_matching_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bsdm_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bsdm_pkg::rsp_t      rsp
);

    // Sequencer state and control registers.
    bsdm_pkg::state_t                  state_reg, state_next;
    logic [bsdm_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [bsdm_pkg::CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [bsdm_pkg::CNT_W-1:0]        keep_reg, keep_next;
    logic                              pend_reg, pend_next;
    logic                              rsp_valid_reg, rsp_valid_next;

    // Payload registers; these need no reset.
    bsdm_pkg::req_t                    req_reg;
    logic [1:0]                        status_reg, status_next;
    logic [bsdm_pkg::DATA_W-1:0]       topv_reg, topv_next;
    bsdm_pkg::rsp_t                    rsp_reg;

    // Memory port signals.
    logic                              wr_en;
    logic [bsdm_pkg::ADDR_W-1:0]       wr_addr;
    logic [bsdm_pkg::DATA_W-1:0]       wr_data;
    logic                              rd_en;
    logic [bsdm_pkg::ADDR_W-1:0]       rd_addr;
    logic [bsdm_pkg::DATA_W-1:0]       rd_data;

    logic                              accept;
    logic                              rsp_load;
    logic                              stack_empty;
    logic                              stack_full;
    logic                              issue;
    logic [bsdm_pkg::CNT_W-1:0]        cnt_dec;

    bsdm_mem u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A new request is taken only while the sequencer is idle.
    assign req_stall   = (state_reg != bsdm_pkg::ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign stack_empty = (cnt_reg == '0);
    assign stack_full  = (cnt_reg >= bsdm_pkg::CNT_W'(bsdm_pkg::CAPACITY));
    assign cnt_dec     = cnt_reg - 1'b1;

    // During the delete walk a read is issued for every stored entry in turn.
    assign issue = (rd_idx_reg < cnt_reg);

    // The result register is free when it is empty or its contents leave this cycle.
    assign rsp_load = (state_reg == bsdm_pkg::ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsdm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bsdm_pkg::ST_EXEC;
                end
            end
            bsdm_pkg::ST_EXEC:
            begin
                case (req_reg.req_type)
                    bsdm_pkg::REQ_TOP,
                    bsdm_pkg::REQ_POP_TOP:
                    begin
                        state_next = stack_empty ? bsdm_pkg::ST_DONE : bsdm_pkg::ST_READ;
                    end
                    bsdm_pkg::REQ_DELETE:
                    begin
                        state_next = bsdm_pkg::ST_DEL;
                    end
                    default:
                    begin
                        state_next = bsdm_pkg::ST_DONE;
                    end
                endcase
            end
            bsdm_pkg::ST_READ:
            begin
                state_next = bsdm_pkg::ST_DONE;
            end
            bsdm_pkg::ST_DEL:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = bsdm_pkg::ST_DONE;
                end
            end
            bsdm_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = bsdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsdm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        keep_next   = keep_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        topv_next   = topv_reg;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[bsdm_pkg::ADDR_W-1:0];
        wr_data     = req_reg.value;
        rd_en       = 1'b0;
        rd_addr     = cnt_dec[bsdm_pkg::ADDR_W-1:0];

        // Results leave when taken; a new one may be loaded in the same cycle.
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end

        case (state_reg)
            bsdm_pkg::ST_EXEC:
            begin
                status_next = bsdm_pkg::STATUS_OK;
                topv_next   = '0;
                rd_idx_next = '0;
                keep_next   = '0;
                case (req_reg.req_type)
                    bsdm_pkg::REQ_PUSH:
                    begin
                        if (stack_full)
                        begin
                            status_next = bsdm_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    bsdm_pkg::REQ_POP:
                    begin
                        if (stack_empty)
                        begin
                            status_next = bsdm_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            cnt_next = cnt_dec;
                        end
                    end
                    bsdm_pkg::REQ_TOP,
                    bsdm_pkg::REQ_POP_TOP:
                    begin
                        if (stack_empty)
                        begin
                            status_next = bsdm_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    bsdm_pkg::REQ_CLEAR:
                    begin
                        if (stack_empty)
                        begin
                            status_next = bsdm_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            cnt_next = '0;
                        end
                    end
                    default:
                    begin
                        // Delete matching starts its walk; unused codes change nothing.
                    end
                endcase
            end
            bsdm_pkg::ST_READ:
            begin
                topv_next = rd_data;
                if (req_reg.req_type == bsdm_pkg::REQ_POP_TOP)
                begin
                    cnt_next = cnt_dec;
                end
            end
            bsdm_pkg::ST_DEL:
            begin
                // Read the next entry while the previous one is compared and, if kept,
                // written down at the compaction index, which never passes the read index.
                rd_addr = rd_idx_reg[bsdm_pkg::ADDR_W-1:0];
                if (issue)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (pend_reg && (rd_data != req_reg.value))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = keep_reg[bsdm_pkg::ADDR_W-1:0];
                    wr_data   = rd_data;
                    keep_next = keep_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    cnt_next = keep_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsdm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            keep_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            keep_reg      <= keep_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        status_reg <= status_next;
        topv_reg   <= topv_next;
        if (rsp_load)
        begin
            rsp_reg.status    <= status_reg;
            rsp_reg.top_value <= topv_reg;
            rsp_reg.depth     <= bsdm_pkg::to_depth(cnt_reg);
            rsp_reg.is_empty  <= stack_empty;
            rsp_reg.is_full   <= (cnt_reg == bsdm_pkg::CNT_W'(bsdm_pkg::CAPACITY));
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

>>> rtl/bsdm_mem.sv
// Entry store of the stack: one write port and one registered read port.
`default_nettype none
module bsdm_mem
(
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [bsdm_pkg::ADDR_W-1:0]     wr_addr,
    input  wire logic [bsdm_pkg::DATA_W-1:0]     wr_data,
    input  wire logic                            rd_en,
    input  wire logic [bsdm_pkg::ADDR_W-1:0]     rd_addr,
    output logic      [bsdm_pkg::DATA_W-1:0]     rd_data
);

    logic [bsdm_pkg::DATA_W-1:0] mem [bsdm_pkg::CAPACITY];
    logic [bsdm_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> tb/sv/bounded_stack_with_delete_matching_core_test.sv
// Self-checking testbench for the bounded stack core with its delete-matching request.
module bounded_stack_with_delete_matching_core_test;
    import bsdm_pkg::*;

    // The tracker keeps its own copy of the stack. Every accepted request is applied to
    // that copy at once, and the response that the core owes for it is queued. Responses
    // leave the core in request order, so each one is checked against the oldest entry.
    class stack_tracker;
        logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
        int unsigned              shadow_fill;
        rsp_t                     due_responses [$];
        int unsigned              mismatches;

        function new();
            shadow_fill = 0;
            mismatches  = 0;
        endfunction

        function void note_request(req_t r);
            rsp_t        owed;
            int unsigned keep;
            owed.status    = STATUS_OK;
            owed.top_value = '0;
            case (r.req_type)
                REQ_PUSH:
                begin
                    if (shadow_fill >= CAPACITY)
                    begin
                        owed.status = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        shadow_entries[shadow_fill] = r.value;
                        shadow_fill++;
                    end
                end
                REQ_POP, REQ_TOP, REQ_POP_TOP, REQ_CLEAR:
                begin
                    if (shadow_fill == 0)
                    begin
                        owed.status = STATUS_UNDERFLOW;
                    end
                    else if (r.req_type == REQ_CLEAR)
                    begin
                        shadow_fill = 0;
                    end
                    else
                    begin
                        if (r.req_type != REQ_POP)
                        begin
                            owed.top_value = shadow_entries[shadow_fill - 1];
                        end
                        if (r.req_type != REQ_TOP)
                        begin
                            shadow_fill--;
                        end
                    end
                end
                REQ_DELETE:
                begin
                    // Survivors slide down in their original order.
                    keep = 0;
                    for (int i = 0; i < shadow_fill; i++)
                    begin
                        if (shadow_entries[i] != r.value)
                        begin
                            shadow_entries[keep] = shadow_entries[i];
                            keep++;
                        end
                    end
                    shadow_fill = keep;
                end
                default:
                begin
                    // The two unused codes leave the stack alone and report success.
                end
            endcase
            owed.depth    = DEPTH_W'(shadow_fill);
            owed.is_empty = (shadow_fill == 0);
            owed.is_full  = (shadow_fill == CAPACITY);
            due_responses.push_back(owed);
        endfunction

        function void check_response(rsp_t got);
            rsp_t owed;
            if (due_responses.size() == 0)
            begin
                $error("response with none outstanding: status %0d depth %0d",
                       got.status, got.depth);
                mismatches++;
                return;
            end
            owed = due_responses.pop_front();
            if (got.status !== owed.status)
            begin
                $error("status: expected %0d, got %0d", owed.status, got.status);
                mismatches++;
            end
            if (got.top_value !== owed.top_value)
            begin
                $error("top_value: expected %0d, got %0d", owed.top_value, got.top_value);
                mismatches++;
            end
            if (got.depth !== owed.depth)
            begin
                $error("depth: expected %0d, got %0d", owed.depth, got.depth);
                mismatches++;
            end
            if (got.is_empty !== owed.is_empty)
            begin
                $error("is_empty: expected %0d, got %0d", owed.is_empty, got.is_empty);
                mismatches++;
            end
            if (got.is_full !== owed.is_full)
            begin
                $error("is_full: expected %0d, got %0d", owed.is_full, got.is_full);
                mismatches++;
            end
        endfunction
    endclass

    localparam int unsigned RANDOM_REQUESTS = 1500;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    stack_tracker tracker = new();
    int unsigned  requests_sent;
    // While calm is set neither side idles, so the core sees a long unbroken stretch.
    bit           calm;

    bounded_stack_with_delete_matching_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sender side. The valid line is lowered only when a gap is actually taken, so a
    // request that follows straight on keeps valid high without a second assignment.
    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_request(input logic [2:0] code, input logic signed [DATA_W-1:0] val);
        req_t r;
        calm = (requests_sent >= 600 && requests_sent < 900);
        idle_gap();
        r.req_type = code;
        r.value    = val;
        req       <= r;
        req_valid <= 1'b1;
        // The request is taken at the first edge at which the core does not stall it.
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        tracker.note_request(r);
        requests_sent++;
    endtask

    // Hold off until the core has answered every request it has taken.
    task automatic wait_for_quiet();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.due_responses.size() != 0);
    endtask

    // Values are often drawn from a small pool so that deletes find several copies.
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 60)
        begin
            return $urandom;
        end
        case ($urandom_range(5))
            0: return 32'sh0000_0000;
            1: return -32'sd1;
            2: return 32'sd1;
            3: return 32'sd7;
            4: return 32'sh7FFF_FFFF;
            default: return 32'sh8000_0000;
        endcase
    endfunction

    function automatic logic [2:0] pick_code(input int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
        begin
            return REQ_PUSH;
        end
        roll = $urandom_range(99);
        if (roll < 22)
        begin
            return REQ_POP;
        end
        if (roll < 44)
        begin
            return REQ_TOP;
        end
        if (roll < 66)
        begin
            return REQ_POP_TOP;
        end
        if (roll < 71)
        begin
            return REQ_CLEAR;
        end
        if (roll < 94)
        begin
            return REQ_DELETE;
        end
        // Unused codes six and seven.
        return 3'($urandom_range(6, 7));
    endfunction

    // A delete usually names a value that is on the stack, so that it really removes entries.
    function automatic logic signed [DATA_W-1:0] delete_key();
        if (tracker.shadow_fill > 0 && $urandom_range(99) < 70)
        begin
            return tracker.shadow_entries[$urandom_range(tracker.shadow_fill - 1)];
        end
        return pick_value();
    endfunction

    task automatic run_mixed(input int unsigned count, input int unsigned push_pct);
        logic [2:0] code;
        repeat (count)
        begin
            code = pick_code(push_pct);
            if (code == REQ_DELETE)
            begin
                send_request(code, delete_key());
            end
            else
            begin
                send_request(code, pick_value());
            end
        end
    endtask

    // Push until the stack is full, knock on it a few times for overflow, then delete
    // one value while the stack is at its deepest, which is the slowest request of all.
    task automatic run_fill();
        while (tracker.shadow_fill < CAPACITY)
        begin
            send_request(REQ_PUSH, pick_value());
        end
        repeat ($urandom_range(1, 3))
        begin
            send_request(REQ_PUSH, pick_value());
        end
        send_request(REQ_DELETE, delete_key());
    endtask

    // Take everything off again, then ask once more on the empty stack for underflow.
    task automatic run_drain();
        while (tracker.shadow_fill > 0)
        begin
            case ($urandom_range(3))
                0: send_request(REQ_TOP, pick_value());
                1: send_request(REQ_POP, pick_value());
                default: send_request(REQ_POP_TOP, pick_value());
            endcase
        end
        case ($urandom_range(3))
            0: send_request(REQ_POP, pick_value());
            1: send_request(REQ_TOP, pick_value());
            2: send_request(REQ_POP_TOP, pick_value());
            default: send_request(REQ_CLEAR, pick_value());
        endcase
    endtask

    // Short directed opening: every request on the empty stack, the unused codes, the
    // extreme values, a delete that removes two copies, one from the middle, a delete that
    // finds nothing, and a delete that empties the stack.
    task automatic run_directed();
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_TOP, 32'sd0);
        send_request(REQ_POP_TOP, 32'sd0);
        send_request(REQ_CLEAR, 32'sd0);
        send_request(REQ_DELETE, 32'sd0);
        send_request(3'd6, 32'sh5555_5555);
        send_request(3'd7, -32'sd1);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'sd0);
        send_request(REQ_PUSH, -32'sd1);
        send_request(REQ_PUSH, 32'sh8000_0000);
        send_request(REQ_TOP, 32'sd0);
        send_request(REQ_DELETE, 32'sh8000_0000);
        send_request(REQ_DELETE, 32'sd12345);
        send_request(REQ_POP_TOP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_TOP, 32'sd0);
        send_request(REQ_PUSH, 32'sh5555_5555);
        send_request(REQ_PUSH, 32'shAAAA_AAAA);
        send_request(REQ_CLEAR, 32'sd0);
        send_request(REQ_PUSH, 32'sd5);
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_PUSH, 32'sd1);
        send_request(REQ_POP_TOP, 32'sd0);
    endtask

    // Receiver side. A response counts at an edge where valid is high and we are not
    // stalling it; the stall for the next cycle is then chosen at random.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                tracker.check_response(rsp);
            end
            rsp_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    // Main sequence.
    initial
    begin
        int unsigned random_target;
        int unsigned episode;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        calm          = 1'b0;
        requests_sent = 0;
        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        // The sender stands back once until the core has answered everything.
        wait_for_quiet();

        // The random part starts by filling the stack so that overflow is always reached.
        random_target = requests_sent + RANDOM_REQUESTS;
        run_fill();
        while (requests_sent < random_target)
        begin
            episode = $urandom_range(9);
            if (episode < 2)
            begin
                run_fill();
            end
            else if (episode == 2)
            begin
                run_drain();
            end
            else if (episode == 3)
            begin
                wait_for_quiet();
                run_mixed($urandom_range(10, 40), 50);
            end
            else
            begin
                run_mixed($urandom_range(10, 40), $urandom_range(25, 75));
            end
        end

        // Let the last responses arrive, then allow a full delete walk for anything stray.
        wait_for_quiet();
        repeat (CAPACITY + 8)
        begin
            @(posedge clk);
        end
        if (tracker.mismatches == 0 && tracker.due_responses.size() == 0)
        begin
            $display("bounded_stack_with_delete_matching_core regression: pass");
        end
        else
        begin
            $display("bounded_stack_with_delete_matching_core regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, where every request is a full delete walk.
    initial
    begin
        #5000000;
        $display("bounded_stack_with_delete_matching_core regression: fail");
        $finish;
    end

endmodule

>>> bounded_stack_with_delete_matching_core.f
rtl/bsdm_pkg.sv
rtl/bsdm_mem.sv
rtl/bounded_stack_with_delete_matching_core.sv
tb/sv/bounded_stack_with_delete_matching_core_test.sv
